### design/dtdds_pkg.sv
`timescale 1ns / 1ps

package dtdds_pkg;

    // Field widths
    localparam int STEP_W = 26;
    localparam int FRAC_W = 16;
    localparam int ADC_W  = 12;
    localparam int OUT_W  = 12;
    localparam int SINE_W = 16;

    // Fixed arithmetic constants
    localparam int SINE_AMP     = 32767;
    localparam int SCALE_SHIFT  = 18;
    localparam int OUT_OFFSET   = 1200;
    localparam int VOLUME_RESET = 2400;

    // Register indexes, decoded from paddr[2]
    localparam logic REG_TONE_A = 1'b0;
    localparam logic REG_TONE_B = 1'b1;

    // Input beat kinds
    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_ADC  = 1'b1
    } t_kind;

    // One converter sample handed to the averaging unit
    typedef struct packed {
        logic             valid;
        logic [ADC_W-1:0] sample;
    } t_adc_beat;

endpackage

### design/dtdds_ram.sv
`timescale 1ns / 1ps

module dtdds_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/dtdds_sine.sv
`timescale 1ns / 1ps

module dtdds_sine #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic        [$clog2(TABLE_SIZE)-1:0] i_index,
    output logic signed [dtdds_pkg::SINE_W-1:0]  o_value
);

    import dtdds_pkg::*;

    localparam int TW    = $clog2(TABLE_SIZE);
    localparam int QW    = TW - 2;
    localparam int Q     = 1 << QW;
    localparam int AMP_W = 15;
    localparam logic [63:0] PIHALF_Q62 = 64'h6487ED5110B4611A;

    // (a*b) >> 62 over the full 128-bit product, kept to 64 bits.
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Quarter-wave table, entries 0 to Q, built by a Taylor series at elaboration.
    function automatic logic [(Q+1)*AMP_W-1:0] build_qtab();
        logic [(Q+1)*AMP_W-1:0] tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] num;
        logic [63:0] res;
        int          k;
        int          n;
        tab = '0;
        for (k = 1; k <= Q; k++) begin
            num = 64'(4 * k);
            if (num >= 64'(TABLE_SIZE)) begin
                res = 64'(SINE_AMP);
            end else begin
                x = (PIHALF_Q62 / 64'(TABLE_SIZE)) * num
                    + ((PIHALF_Q62 % 64'(TABLE_SIZE)) * num) / 64'(TABLE_SIZE);
                x2   = mul_q62(x, x);
                term = x;
                sum  = x;
                for (n = 1; n < 40 && term != 64'd0; n++) begin
                    term = mul_q62(term, x2) / 64'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
                res = mul_q62(sum, 64'(SINE_AMP));
            end
            tab[k*AMP_W +: AMP_W] = res[AMP_W-1:0];
        end
        return tab;
    endfunction

    localparam logic [(Q+1)*AMP_W-1:0] QTAB = build_qtab();

    logic [1:0]       w_quadrant;
    logic [QW-1:0]    w_offset;
    logic [QW:0]      w_qindex;
    logic [AMP_W-1:0] w_entry;
    logic [SINE_W-1:0] w_mag;

    // Fold the index into the first quadrant, look up, then restore the sign.
    always_comb begin
        w_quadrant = i_index[TW-1 -: 2];
        w_offset   = i_index[QW-1:0];
        if (w_quadrant[0]) begin
            w_qindex = (QW+1)'(Q) - {1'b0, w_offset};
        end else begin
            w_qindex = {1'b0, w_offset};
        end
        w_entry = QTAB[w_qindex*AMP_W +: AMP_W];
        w_mag   = {1'b0, w_entry};
        if (w_quadrant[1]) begin
            o_value = -$signed(w_mag);
        end else begin
            o_value = $signed(w_mag);
        end
    end

endmodule

### design/dtdds_volume.sv
`timescale 1ns / 1ps

module dtdds_volume #(
    parameter int AVERAGE_LENGTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dtdds_pkg::t_adc_beat        i_adc,
    output logic [dtdds_pkg::ADC_W-1:0] o_volume
);

    import dtdds_pkg::*;

    localparam int AW    = $clog2(AVERAGE_LENGTH);
    localparam int SUM_W = ADC_W + AW;

    logic [AW-1:0]    r_pos;
    logic [AW-1:0]    n_pos;
    logic             r_filled;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic [ADC_W-1:0] r_volume;
    logic [ADC_W-1:0] w_rd_data;
    logic [ADC_W-1:0] w_old;
    logic [AW-1:0]    w_rd_addr;

    // The ring keeps the read port on the current slot, so the oldest sample
    // is already waiting when the next one arrives. Slots not yet written
    // since reset count as zero.
    always_comb begin
        n_pos     = r_pos + AW'(1);
        w_old     = r_filled ? w_rd_data : '0;
        n_sum     = r_sum - SUM_W'(w_old) + SUM_W'(i_adc.sample);
        w_rd_addr = i_adc.valid ? n_pos : r_pos;
    end

    dtdds_ram #(
        .WIDTH (ADC_W),
        .DEPTH (AVERAGE_LENGTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (i_adc.valid),
        .i_wr_addr (r_pos),
        .i_wr_data (i_adc.sample),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Running sum, position and average level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_filled <= 1'b0;
            r_sum    <= '0;
            r_volume <= ADC_W'(VOLUME_RESET);
        end else if (i_adc.valid) begin
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_volume <= n_sum[AW +: ADC_W];
            if (r_pos == AW'(AVERAGE_LENGTH - 1)) begin
                r_filled <= 1'b1;
            end
        end
    end

    assign o_volume = r_volume;

endmodule

### design/dual_tone_dds_with_boxcar_volume.sv
`timescale 1ns / 1ps

// Channel  Handshake                  Payload
// input    i_in_valid / o_in_ready    i_kind, i_adc_sample
// output   o_out_valid / i_out_ready  o_pwm_compare
// config   psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// One input beat is taken every cycle while stage one is free. A tick is stepped and
// captured at acceptance and reaches the output register through two registered stages
// (table lookup and mix, then volume multiply); a converter sample is complete in the
// cycle it is accepted. The sample ring needs no clearing pass at reset, as a fill
// flag masks slots not yet written. A stalled output holds its beat while
// the two stages behind it keep filling; input stalls only when all are full.
// TABLE_SIZE and AVERAGE_LENGTH must be powers of two.

module dual_tone_dds_with_boxcar_volume #(
    parameter int TABLE_SIZE     = 1024,
    parameter int AVERAGE_LENGTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_kind,
    input  logic [dtdds_pkg::ADC_W-1:0] i_adc_sample,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [dtdds_pkg::OUT_W-1:0] o_pwm_compare,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import dtdds_pkg::*;

    localparam int TW    = $clog2(TABLE_SIZE);
    localparam int TOP_W = TW + FRAC_W;
    localparam int PW    = (TOP_W >= STEP_W) ? TOP_W : 32;
    localparam int SW    = (PW == 32) ? 32 : PW + 1;
    localparam logic [SW-1:0] TOP = SW'(1) << TOP_W;
    localparam int MIX_W  = SINE_W + 1;
    localparam int PROD_W = MIX_W + ADC_W + 1;

    logic [STEP_W-1:0] r_step_a;
    logic [STEP_W-1:0] r_step_b;
    logic [PW-1:0]     r_phase_a;
    logic [PW-1:0]     r_phase_b;
    logic [PW-1:0]     n_phase_a;
    logic [PW-1:0]     n_phase_b;

    logic              r_s1_valid;
    logic [TW-1:0]     r_s1_idx_a;
    logic [TW-1:0]     r_s1_idx_b;
    logic [ADC_W-1:0]  r_s1_vol;
    logic              r_s2_valid;
    logic signed [MIX_W-1:0] r_s2_mix;
    logic [ADC_W-1:0]  r_s2_vol;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic              w_out_free;
    logic              w_s2_free;
    logic              w_s1_free;
    logic              w_s2_adv;
    logic              w_s1_adv;
    logic              w_in_fire;
    logic              w_tick_fire;
    logic              w_cfg_wr;
    logic [STEP_W-1:0] w_cfg_step;
    t_adc_beat         w_adc;
    logic [ADC_W-1:0]  w_volume;

    logic signed [SINE_W-1:0] w_sine_a;
    logic signed [SINE_W-1:0] w_sine_b;
    logic signed [MIX_W-1:0]  w_mix;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_scaled;
    logic [OUT_W-1:0]         n_out;

    // Phase step with a single wrap at the top of the table.
    function automatic logic [PW-1:0] advance(input logic [PW-1:0] phase,
                                              input logic [STEP_W-1:0] step);
        logic [SW-1:0] sum;
        sum = SW'(phase) + SW'(step);
        if (sum >= TOP) begin
            sum = sum - TOP;
        end
        return sum[PW-1:0];
    endfunction

    // Pipeline flow control: each stage moves when the one ahead is free.
    always_comb begin
        w_out_free  = !r_out_valid || i_out_ready;
        w_s2_adv    = r_s2_valid && w_out_free;
        w_s2_free   = !r_s2_valid || w_out_free;
        w_s1_adv    = r_s1_valid && w_s2_free;
        w_s1_free   = !r_s1_valid || w_s2_free;
        w_in_fire   = i_in_valid && w_s1_free;
        w_tick_fire = w_in_fire && (i_kind == KIND_TICK);
    end

    assign o_in_ready = w_s1_free;

    // Configuration port.
    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite;
    assign w_cfg_step = pwdata[STEP_W-1:0];
    assign prdata     = (paddr[2] == REG_TONE_B) ? {(32 - STEP_W)'(0), r_step_b}
                                                 : {(32 - STEP_W)'(0), r_step_a};

    // Phase accumulators advance on every accepted tick, unless that tone's step is written then.
    assign n_phase_a = advance(r_phase_a, r_step_a);
    assign n_phase_b = advance(r_phase_b, r_step_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_a  <= '0;
            r_step_b  <= '0;
            r_phase_a <= '0;
            r_phase_b <= '0;
        end else begin
            if (w_cfg_wr && paddr[2] == REG_TONE_A) begin
                r_step_a <= w_cfg_step;
                if (w_cfg_step == '0) begin
                    r_phase_a <= '0;
                end
            end else if (w_tick_fire) begin
                r_phase_a <= n_phase_a;
            end
            if (w_cfg_wr && paddr[2] == REG_TONE_B) begin
                r_step_b <= w_cfg_step;
                if (w_cfg_step == '0) begin
                    r_phase_b <= '0;
                end
            end else if (w_tick_fire) begin
                r_phase_b <= n_phase_b;
            end
        end
    end

    // Converter samples go straight to the averaging unit.
    assign w_adc.valid  = w_in_fire && (i_kind == KIND_ADC);
    assign w_adc.sample = i_adc_sample;

    dtdds_volume #(
        .AVERAGE_LENGTH (AVERAGE_LENGTH)
    ) u_volume (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adc    (w_adc),
        .o_volume (w_volume)
    );

    // Stage one looks up both tones and mixes them.
    dtdds_sine #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_sine_a (
        .i_index (r_s1_idx_a),
        .o_value (w_sine_a)
    );

    dtdds_sine #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_sine_b (
        .i_index (r_s1_idx_b),
        .o_value (w_sine_b)
    );

    assign w_mix = {w_sine_a[SINE_W-1], w_sine_a} + {w_sine_b[SINE_W-1], w_sine_b};

    // Stage two scales by the volume captured with the tick and adds the offset.
    always_comb begin
        w_prod   = r_s2_mix * $signed({1'b0, r_s2_vol});
        w_scaled = w_prod >>> SCALE_SHIFT;
        n_out    = w_scaled[OUT_W-1:0] + OUT_W'(OUT_OFFSET);
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= w_tick_fire;
            end
            if (w_s2_free) begin
                r_s2_valid <= w_s1_adv;
            end
            if (w_out_free) begin
                r_out_valid <= w_s2_adv;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (w_tick_fire) begin
            r_s1_idx_a <= n_phase_a[FRAC_W +: TW];
            r_s1_idx_b <= n_phase_b[FRAC_W +: TW];
            r_s1_vol   <= w_volume;
        end
        if (w_s1_adv) begin
            r_s2_mix <= w_mix;
            r_s2_vol <= r_s1_vol;
        end
        if (w_s2_adv) begin
            r_out_data <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pwm_compare = r_out_data;

    // A result beat always lies in the reachable compare range.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pwm_compare >= OUT_W'(176) && o_pwm_compare <= OUT_W'(2223)))
        else $error("compare value out of range");

    // A stage one beat that cannot move keeps its indexes.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=> (r_s1_valid && $stable(r_s1_idx_a)
                                       && $stable(r_s1_idx_b)))
        else $error("stage one beat lost while stalled");

    // Writing a zero step to tone A clears the phase of tone A.
    a_zero_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && paddr[2] == REG_TONE_A && w_cfg_step == '0) |=> (r_phase_a == '0))
        else $error("phase A not cleared by zero step");

    // With a large enough table the phase never leaves its range.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (PW == 32) || (SW'(r_phase_a) < TOP && SW'(r_phase_b) < TOP))
        else $error("phase beyond table top");

endmodule

### sim/tone_mix_checker.sv
`timescale 1ns / 1ps

module tone_mix_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_kind,
    input  logic [dtdds_pkg::ADC_W-1:0] i_adc_sample,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [dtdds_pkg::OUT_W-1:0] i_pwm_compare,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    input  logic [31:0]                 prdata,
    input  logic                        pready,
    output int unsigned                 o_mismatches,
    output int unsigned                 o_pending
);

    import dtdds_pkg::*;

    localparam int TABLE_SIZE   = 1024;
    localparam int AVG_LEN      = 32;
    localparam int AVG_SHIFT    = 5;
    localparam real HALF_PI     = 1.5707963267948966;
    localparam logic [STEP_W:0] PHASE_TOP = (STEP_W+1)'(TABLE_SIZE) << FRAC_W;

    // Sine table, rebuilt here from quarter-wave symmetry.
    logic signed [SINE_W-1:0] sine_tab [0:TABLE_SIZE-1];

    // Own copy of the block's state and registers.
    logic [STEP_W-1:0] step_a, step_b;
    logic [STEP_W-1:0] phase_a, phase_b;
    logic [ADC_W-1:0]  volume;
    logic [ADC_W-1:0]  level_ring [0:AVG_LEN-1];
    logic [16:0]       level_total;
    logic [4:0]        level_pos;

    // Compare values still owed by the block, oldest first.
    logic [OUT_W-1:0]  pwm_expected [$];

    initial begin : build_sine
        int unsigned quad, rem, fold;
        int mag;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            quad = (4 * i) / TABLE_SIZE;
            rem  = (4 * i) % TABLE_SIZE;
            fold = quad[0] ? TABLE_SIZE - rem : rem;
            if (fold == 0)
                mag = 0;
            else if (fold >= TABLE_SIZE)
                mag = SINE_AMP;
            else
                mag = $rtoi(real'(SINE_AMP) * $sin(HALF_PI * fold / TABLE_SIZE));
            sine_tab[i] = SINE_W'(quad >= 2 ? -mag : mag);
        end
    end

    // One phase accumulator step with a single wrap at the table end.
    function automatic logic [STEP_W-1:0] advance_phase(input logic [STEP_W-1:0] ph,
                                                        input logic [STEP_W-1:0] st);
        logic [STEP_W:0] sum;
        sum = {1'b0, ph} + {1'b0, st};
        if (sum >= PHASE_TOP)
            sum = sum - PHASE_TOP;
        return sum[STEP_W-1:0];
    endfunction

    // A tick: move both tones on, mix them and scale by the current volume.
    task automatic predict_pwm(output logic [OUT_W-1:0] pwm);
        int mix;
        int scaled;
        phase_a = advance_phase(phase_a, step_a);
        phase_b = advance_phase(phase_b, step_b);
        mix = int'(sine_tab[phase_a[STEP_W-1:FRAC_W]])
            + int'(sine_tab[phase_b[STEP_W-1:FRAC_W]]);
        mix = mix * int'({20'd0, volume});
        scaled = (mix >>> SCALE_SHIFT) + OUT_OFFSET;
        pwm = scaled[OUT_W-1:0];
    endtask

    // A converter sample replaces the oldest ring slot and sets the volume.
    task automatic take_level(input logic [ADC_W-1:0] sample);
        level_total = level_total - {5'd0, level_ring[level_pos]} + {5'd0, sample};
        level_ring[level_pos] = sample;
        level_pos = level_pos + 5'd1;
        volume = level_total[AVG_SHIFT +: ADC_W];
    endtask

    always @(posedge i_clk) begin : watch
        logic [OUT_W-1:0] want;
        logic [31:0]      reg_val;
        int unsigned      errs;
        if (!i_rst_n) begin
            step_a      = '0;
            step_b      = '0;
            phase_a     = '0;
            phase_b     = '0;
            volume      = ADC_W'(VOLUME_RESET);
            level_total = '0;
            level_pos   = '0;
            for (int i = 0; i < AVG_LEN; i++)
                level_ring[i] = '0;
            pwm_expected.delete();
            o_mismatches <= 0;
            o_pending    <= 0;
        end else begin
            errs = 0;
            // Output beats are checked before this edge's input is predicted.
            if (i_out_valid && i_out_ready) begin
                if (pwm_expected.size() == 0) begin
                    $display("%0t: unexpected pwm_compare beat, expected none, got %0d",
                             $time, i_pwm_compare);
                    errs++;
                end else begin
                    want = pwm_expected.pop_front();
                    if (i_pwm_compare !== want) begin
                        $display("%0t: pwm_compare mismatch, expected %0d, got %0d",
                                 $time, want, i_pwm_compare);
                        errs++;
                    end
                end
            end

            // Register reads return the stored step.
            if (psel && penable && !pwrite && pready) begin
                reg_val = {{(32-STEP_W){1'b0}}, (paddr[2] == REG_TONE_A) ? step_a : step_b};
                if (prdata !== reg_val) begin
                    $display("%0t: prdata mismatch at %0d, expected %0h, got %0h",
                             $time, paddr, reg_val, prdata);
                    errs++;
                end
            end

            // Register writes; a zero step also parks that tone's phase.
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_TONE_A) begin
                    step_a = pwdata[STEP_W-1:0];
                    if (step_a == '0)
                        phase_a = '0;
                end else begin
                    step_b = pwdata[STEP_W-1:0];
                    if (step_b == '0)
                        phase_b = '0;
                end
            end

            if (i_in_valid && i_in_ready) begin
                if (i_kind == KIND_ADC) begin
                    take_level(i_adc_sample);
                end else begin
                    predict_pwm(want);
                    pwm_expected.push_back(want);
                end
            end
            o_mismatches <= o_mismatches + errs;
            o_pending    <= pwm_expected.size();
        end
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import dtdds_pkg::*;

    localparam int          SETTLE_CYCLES = 10;
    localparam int          HOLD_CYCLES   = 60;
    localparam int          SEGMENTS      = 10;
    localparam longint      LIMIT_NS      = 3_000_000;
    localparam logic [STEP_W-1:0] STEP_MAX     = '1;
    localparam logic [STEP_W-1:0] STEP_QUARTER = STEP_W'(256) << FRAC_W;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_ready;
    logic              i_kind       = KIND_TICK;
    logic [ADC_W-1:0]  i_adc_sample = '0;
    logic              o_out_valid;
    logic              i_out_ready  = 1'b0;
    logic [OUT_W-1:0]  o_pwm_compare;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [2:0]        paddr        = '0;
    logic [31:0]       pwdata       = '0;
    logic [31:0]       prdata;
    logic              pready;

    int unsigned       mismatches;
    int unsigned       pending;

    // Stimulus controls shared with the receiver.
    logic              gaps_on   = 1'b1;
    int unsigned       holds_asked  = 0;
    int unsigned       holds_served = 0;
    int unsigned       hold_left    = 0;

    dual_tone_dds_with_boxcar_volume dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_adc_sample  (i_adc_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pwm_compare (o_pwm_compare),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    tone_mix_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_adc_sample  (i_adc_sample),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_pwm_compare (o_pwm_compare),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: random back-pressure, with a long hold-off whenever one is asked for.
    always @(posedge i_clk) begin
        if (holds_asked != holds_served) begin
            holds_served = holds_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (gaps_on) begin
            i_out_ready <= ($urandom_range(99) >= 25);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Offer one input beat and return at the edge where it is taken.
    task automatic send_beat(input t_kind kind, input logic [ADC_W-1:0] sample);
        while (gaps_on && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_adc_sample <= sample;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // Stop offering and let every outstanding compare value come out.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer: setup phase, access phase, then rest with psel low.
    task automatic apb_access(input logic wr, input logic reg_sel, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write a step with junk in the unused upper bits, then read it back.
    task automatic write_step(input logic reg_sel, input logic [STEP_W-1:0] st);
        apb_access(1'b1, reg_sel, {(32 - STEP_W)'($urandom >> STEP_W), st});
        apb_access(1'b0, reg_sel, $urandom);
    endtask

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(6))
            0: return '0;
            1: return STEP_MAX;
            2: return STEP_W'(1);
            3: return STEP_QUARTER;
            4: return STEP_W'($urandom_range(4 << FRAC_W));
            default: return STEP_W'($urandom);
        endcase
    endfunction

    // Watchdog.
    initial begin
        #(LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int unsigned      count;
        int unsigned      loudness;
        t_kind            kind;
        logic [ADC_W-1:0] sample;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: both tones parked at phase zero, reset volume.
        send_beat(KIND_TICK, 12'hFFF);
        settle();

        // Quarter-table steps walk through the sine peaks, troughs and the wrap.
        write_step(REG_TONE_A, STEP_QUARTER);
        write_step(REG_TONE_B, STEP_QUARTER);
        repeat (5) send_beat(KIND_TICK, ADC_W'($urandom));
        send_beat(KIND_ADC, 12'hFFF);
        send_beat(KIND_ADC, 12'h000);
        send_beat(KIND_ADC, 12'hAAA);
        send_beat(KIND_ADC, 12'h555);
        repeat (2) send_beat(KIND_TICK, ADC_W'($urandom));
        settle();

        // Largest and smallest steps, then a zero step to park tone A.
        write_step(REG_TONE_A, STEP_MAX);
        write_step(REG_TONE_B, STEP_W'(1));
        repeat (3) send_beat(KIND_TICK, ADC_W'($urandom));
        settle();
        write_step(REG_TONE_A, '0);
        repeat (2) send_beat(KIND_TICK, ADC_W'($urandom));
        settle();

        // Random segments, each with its own steps and loudness profile.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 0) begin
                write_step(REG_TONE_A, STEP_MAX);
                write_step(REG_TONE_B, STEP_MAX);
            end else if (seg == 1) begin
                write_step(REG_TONE_A, STEP_W'(1));
                write_step(REG_TONE_B, '0);
            end else begin
                write_step(REG_TONE_A, pick_step());
                write_step(REG_TONE_B, pick_step());
            end
            gaps_on  = (seg != 4);
            loudness = seg % 3;
            count    = (seg == 4) ? 200 : 92;
            if (seg == 4 || seg == 7)
                holds_asked = holds_asked + 1;
            repeat (count) begin
                kind = ($urandom_range(99) < 60) ? KIND_TICK : KIND_ADC;
                case (loudness)
                    0: sample = ($urandom_range(9) != 0) ? 12'hFFF : ADC_W'($urandom);
                    1: sample = ($urandom_range(9) != 0) ? 12'h000 : ADC_W'($urandom);
                    default: sample = ADC_W'($urandom);
                endcase
                send_beat(kind, sample);
            end
            settle();
        end
        gaps_on = 1'b1;

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
